[hw/rtl/kst_pkg.sv]
// Package for the keyed slot table: sizes, command and status codes,
// sequencer states and the request/response words to the slot store.
// No dependencies.
package kst_pkg;

	localparam int SLOT_COUNT = 64;
	localparam int VALUE_BITS = 64;
	localparam int KEY_BITS   = 64;
	localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	// Head and link words also hold the end mark, which equals SLOT_COUNT
	localparam int HEAD_BITS  = $clog2(SLOT_COUNT + 1);

	localparam logic [HEAD_BITS-1:0] LIST_END = HEAD_BITS'(SLOT_COUNT);

	// Port field widths
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;
	localparam int INDEX_W  = 6;
	localparam int WORD_W   = 64;

	// Commands
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_DELETED   = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd5;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_SCAN,
		CTL_READ,
		CTL_WRITE
	} ctl_state_t;

	typedef struct packed {
		logic [SLOT_BITS-1:0]  rd_addr;
		logic [SLOT_BITS-1:0]  link_addr;
		logic [SLOT_BITS-1:0]  wr_addr;
		logic                  key_we;
		logic                  val_we;
		logic                  link_we;
		logic                  used_set;
		logic                  used_clr;
		logic [KEY_BITS-1:0]   wr_key;
		logic [VALUE_BITS-1:0] wr_val;
		logic [HEAD_BITS-1:0]  wr_link;
	} store_req_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]   rd_key;
		logic                  rd_used;
		logic [VALUE_BITS-1:0] rd_val;
		logic [HEAD_BITS-1:0]  rd_link;
	} store_rsp_t;

endpackage

[hw/rtl/kst_store.sv]
// Slot store: key, value and free-link memories with registered reads,
// plus per-slot used bits and link-written bits in flip-flops.
// Depends on kst_pkg.
module kst_store (
	input  logic                clk,
	input  logic                arst_n,
	input  kst_pkg::store_req_t req,
	output kst_pkg::store_rsp_t rsp
);

	logic [kst_pkg::KEY_BITS-1:0]   key_mem  [kst_pkg::SLOT_COUNT];
	logic [kst_pkg::VALUE_BITS-1:0] val_mem  [kst_pkg::SLOT_COUNT];
	logic [kst_pkg::HEAD_BITS-1:0]  link_mem [kst_pkg::SLOT_COUNT];

	logic [kst_pkg::SLOT_COUNT-1:0] used_q;
	logic [kst_pkg::SLOT_COUNT-1:0] link_set_q;

	logic [kst_pkg::KEY_BITS-1:0]   key_rd_s1;
	logic [kst_pkg::VALUE_BITS-1:0] val_rd_s1;
	logic [kst_pkg::HEAD_BITS-1:0]  link_rd_s1;
	logic [kst_pkg::SLOT_BITS-1:0]  link_addr_s1;
	logic                           link_set_s1;
	logic                           used_rd_s1;
	logic [kst_pkg::HEAD_BITS-1:0]  link_init;

	// Write the memories and register the read words
	always_ff @(posedge clk) begin
		if (req.key_we) begin
			key_mem[req.wr_addr] <= req.wr_key;
		end
		if (req.val_we) begin
			val_mem[req.wr_addr] <= req.wr_val;
		end
		if (req.link_we) begin
			link_mem[req.wr_addr] <= req.wr_link;
		end
		key_rd_s1    <= key_mem[req.rd_addr];
		val_rd_s1    <= val_mem[req.rd_addr];
		used_rd_s1   <= used_q[req.rd_addr];
		link_rd_s1   <= link_mem[req.link_addr];
		link_set_s1  <= link_set_q[req.link_addr];
		link_addr_s1 <= req.link_addr;
	end

	// Track used slots and links that have been rewritten since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			link_set_q <= '0;
		end else begin
			if (req.used_set) begin
				used_q[req.wr_addr] <= 1'b1;
			end
			if (req.used_clr) begin
				used_q[req.wr_addr] <= 1'b0;
			end
			if (req.link_we) begin
				link_set_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	// An untouched link points at the next slot in order
	assign link_init = kst_pkg::HEAD_BITS'(link_addr_s1) + kst_pkg::HEAD_BITS'(1);

	always_comb begin
		rsp.rd_key  = key_rd_s1;
		rsp.rd_used = used_rd_s1;
		rsp.rd_val  = val_rd_s1;
		rsp.rd_link = link_set_s1 ? link_rd_s1 : link_init;
	end

endmodule

[hw/rtl/kst_ctrl.sv]
// Sequencer: scans the slots through one shared key comparator, then
// reads the hit value and free link, applies the update and holds the result.
// Depends on kst_pkg.
module kst_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [kst_pkg::CMD_W-1:0]           command,
	input  logic [kst_pkg::WORD_W-1:0]          lookup_key,
	input  logic [kst_pkg::WORD_W-1:0]          entry_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [kst_pkg::STATUS_W-1:0]        status,
	output logic [kst_pkg::INDEX_W-1:0]         slot_index,
	output logic [kst_pkg::WORD_W-1:0]          value_out,
	output kst_pkg::store_req_t                 req,
	input  kst_pkg::store_rsp_t                 rsp
);

	localparam logic [kst_pkg::SLOT_BITS-1:0] LAST_SLOT =
		kst_pkg::SLOT_BITS'(kst_pkg::SLOT_COUNT - 1);

	kst_pkg::ctl_state_t state_q, state_d;

	logic [kst_pkg::CMD_W-1:0]      cmd_q;
	logic [kst_pkg::KEY_BITS-1:0]   key_q;
	logic [kst_pkg::VALUE_BITS-1:0] val_q;
	logic [kst_pkg::HEAD_BITS-1:0]  scan_q;
	logic                           cmp_vld_s1;
	logic [kst_pkg::SLOT_BITS-1:0]  cmp_idx_s1;
	logic                           hit_q;
	logic [kst_pkg::SLOT_BITS-1:0]  hit_idx_q;
	logic [kst_pkg::HEAD_BITS-1:0]  head_q;
	logic                           out_valid_q;
	logic [kst_pkg::STATUS_W-1:0]   status_q;
	logic [kst_pkg::INDEX_W-1:0]    slot_q;
	logic [kst_pkg::WORD_W-1:0]     value_q;

	logic                           match;
	logic                           last_cmp;
	logic                           issue;
	logic                           head_ok;
	logic                           commit;
	logic [kst_pkg::HEAD_BITS-1:0]  head_d;
	logic [kst_pkg::STATUS_W-1:0]   res_status;
	logic [kst_pkg::SLOT_BITS-1:0]  res_slot;
	logic [kst_pkg::WORD_W-1:0]     res_value;

	// Shared comparator on the registered word read from the previous scan address
	assign match    = cmp_vld_s1 && rsp.rd_used && (rsp.rd_key == key_q);
	assign last_cmp = cmp_vld_s1 && (cmp_idx_s1 == LAST_SLOT);
	assign issue    = (state_q == kst_pkg::CTL_SCAN) && (scan_q < kst_pkg::LIST_END) && !match;
	assign head_ok  = head_q < kst_pkg::LIST_END;
	assign commit   = (state_q == kst_pkg::CTL_WRITE) && (!out_valid_q || out_ready);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kst_pkg::CTL_IDLE: begin
				if (in_valid) begin
					state_d = kst_pkg::CTL_SCAN;
				end
			end
			kst_pkg::CTL_SCAN: begin
				if (match || last_cmp) begin
					state_d = kst_pkg::CTL_READ;
				end
			end
			kst_pkg::CTL_READ: begin
				state_d = kst_pkg::CTL_WRITE;
			end
			kst_pkg::CTL_WRITE: begin
				if (commit) begin
					state_d = kst_pkg::CTL_IDLE;
				end
			end
			default: begin
				state_d = kst_pkg::CTL_IDLE;
			end
		endcase
	end

	// Outputs: store requests, result word and next free-list head
	always_comb begin
		in_ready       = (state_q == kst_pkg::CTL_IDLE);
		req            = '0;
		req.wr_key     = key_q;
		req.wr_val     = val_q;
		req.wr_link    = head_q;
		req.rd_addr    = (state_q == kst_pkg::CTL_SCAN) ?
			scan_q[kst_pkg::SLOT_BITS-1:0] : hit_idx_q;
		req.link_addr  = head_ok ? kst_pkg::SLOT_BITS'(head_q) : '0;
		head_d         = head_q;
		res_status     = kst_pkg::STAT_NOT_FOUND;
		res_slot       = '0;
		res_value      = '0;
		unique case (cmd_q)
			kst_pkg::CMD_INSERT: begin
				if (hit_q) begin
					res_status  = kst_pkg::STAT_UPDATED;
					res_slot    = hit_idx_q;
					req.wr_addr = hit_idx_q;
					req.val_we  = commit;
				end else if (!head_ok) begin
					res_status  = kst_pkg::STAT_FULL;
				end else begin
					res_status   = kst_pkg::STAT_INSERTED;
					res_slot     = kst_pkg::SLOT_BITS'(head_q);
					req.wr_addr  = kst_pkg::SLOT_BITS'(head_q);
					req.key_we   = commit;
					req.val_we   = commit;
					req.used_set = commit;
					head_d       = (rsp.rd_link < kst_pkg::LIST_END) ?
						rsp.rd_link : kst_pkg::LIST_END;
				end
			end
			kst_pkg::CMD_DELETE: begin
				if (hit_q) begin
					res_status   = kst_pkg::STAT_DELETED;
					res_slot     = hit_idx_q;
					req.wr_addr  = hit_idx_q;
					req.used_clr = commit;
					req.link_we  = commit;
					req.wr_link  = head_ok ? head_q : kst_pkg::LIST_END;
					head_d       = kst_pkg::HEAD_BITS'(hit_idx_q);
				end
			end
			kst_pkg::CMD_LOOKUP: begin
				if (hit_q) begin
					res_status = kst_pkg::STAT_FOUND;
					res_slot   = hit_idx_q;
					res_value  = kst_pkg::WORD_W'(rsp.rd_val);
				end
			end
			default: begin
				res_status = kst_pkg::STAT_NOT_FOUND;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kst_pkg::CTL_IDLE;
			scan_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cmp_vld_s1  <= issue;
			out_valid_q <= commit || (out_valid_q && !out_ready);
			if (in_valid && in_ready) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
			end else if (issue) begin
				scan_q <= scan_q + kst_pkg::HEAD_BITS'(1);
			end
			if (match && (state_q == kst_pkg::CTL_SCAN)) begin
				hit_q <= 1'b1;
			end
			if (commit) begin
				head_q <= head_d;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			key_q <= lookup_key;
			val_q <= kst_pkg::VALUE_BITS'(entry_value);
		end
		cmp_idx_s1 <= scan_q[kst_pkg::SLOT_BITS-1:0];
		if (match && (state_q == kst_pkg::CTL_SCAN)) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if (commit) begin
			status_q <= res_status;
			slot_q   <= kst_pkg::INDEX_W'(res_slot);
			value_q  <= res_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign slot_index = slot_q;
	assign value_out  = value_q;

endmodule

[hw/rtl/keyed_slot_table_with_free_list.sv]
// Keyed slot table with free list. On a miss every slot is compared through the single
// key comparator behind the registered store read, then the free link is read and the
// update applied; a hit in slot k stops the scan there before its value is read.
// A new word is taken only while idle, after the previous result is loaded, and a
// result still waiting for out_ready holds the update.
// Reset: used bits and free list return to slot order at once, no clearing pass.
module keyed_slot_table_with_free_list (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [kst_pkg::CMD_W-1:0]    command,
	input  logic [kst_pkg::WORD_W-1:0]   lookup_key,
	input  logic [kst_pkg::WORD_W-1:0]   entry_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [kst_pkg::STATUS_W-1:0] status,
	output logic [kst_pkg::INDEX_W-1:0]  slot_index,
	output logic [kst_pkg::WORD_W-1:0]   value_out
);

	kst_pkg::store_req_t req;
	kst_pkg::store_rsp_t rsp;

	// Sequencer and result register
	kst_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.lookup_key  (lookup_key),
		.entry_value (entry_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.slot_index  (slot_index),
		.value_out   (value_out),
		.req         (req),
		.rsp         (rsp)
	);

	// Slot memories and free-list links
	kst_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

[hw/rtl/kst_chk.sv]
// Port-level checker for the keyed slot table, bound to the top level.
// Depends on kst_pkg.
module kst_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [kst_pkg::STATUS_W-1:0] status,
	input logic [kst_pkg::INDEX_W-1:0]  slot_index,
	input logic [kst_pkg::WORD_W-1:0]   value_out
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(slot_index) && $stable(value_out))
		else $error("result word changed while stalled");

	// Report only defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= kst_pkg::STAT_FOUND)
		else $error("undefined status code");

	// Drive a value only on a found lookup
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != kst_pkg::STAT_FOUND |-> value_out == '0)
		else $error("value on a result other than found");

	// Drop the slot on full and not-found results
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == kst_pkg::STAT_FULL ||
		status == kst_pkg::STAT_NOT_FOUND) |-> slot_index == '0)
		else $error("slot reported where none applies");

	// Go busy after taking a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accepting a word");

endmodule

bind keyed_slot_table_with_free_list kst_chk u_kst_chk (.*);
